// ===== rtl/ppcov_pkg.sv =====
// shared types, constants and arithmetic helpers for the pixel pair covariance block
package ppcov_pkg;

    localparam int CORDIC_STEPS = 30;

    localparam logic [1:0] CFG_NOISE_DIAGONAL   = 2'd0;
    localparam logic [1:0] CFG_NOISE_FLOOR      = 2'd1;
    localparam logic [1:0] CFG_COVARIANCE_SCALE = 2'd2;
    localparam logic [1:0] CFG_CROSS_MODE       = 2'd3;

    localparam logic [25:0] DEG360 = 26'd23592960;
    localparam logic [25:0] DEG180 = 26'd11796480;
    localparam logic [25:0] DEG90  = 26'd5898240;

    localparam logic [26:0] RAD_SCALE   = 27'd74961321;
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    localparam logic [52:0] DATA_POS_MAX = 53'd140737488355327;
    localparam logic [52:0] DATA_NEG_MAX = 53'd140737488355328;

    typedef struct packed {
        logic [22:0] mag;
        logic        sneg;
        logic        cneg;
    } angle_t;

    // fold any angle in degrees Q.16 into the first quadrant
    function automatic angle_t reduce_angle(input logic signed [25:0] deg);
        logic [25:0] m;
        angle_t      r;
        begin
            r.sneg = deg[25];
            r.cneg = 1'b0;
            m = deg[25] ? 26'(-deg) : 26'(deg);
            if (m >= DEG360)
                m = m - DEG360;
            if (m > DEG180)
            begin
                m = DEG360 - m;
                r.sneg = ~r.sneg;
            end
            if (m > DEG90)
            begin
                m = DEG180 - m;
                r.cneg = 1'b1;
            end
            r.mag = m[22:0];
            return r;
        end
    endfunction

    // atan(2^-i) in radians Q.32
    function automatic logic signed [34:0] atan_step(input int i);
        longint r;
        begin
            case (i)
                0: r = 64'sd3373259426;
                1: r = 64'sd1991351318;
                2: r = 64'sd1052175346;
                3: r = 64'sd534100635;
                4: r = 64'sd268086748;
                default:
                begin
                    r = 64'sd1 <<< (32 - i);
                    if (3 * i <= 32)
                        r = r - ((64'sd1 <<< (32 - 3 * i)) / 3);
                    if (5 * i <= 32)
                        r = r + ((64'sd1 <<< (32 - 5 * i)) / 5);
                end
            endcase
            return r[34:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        begin
            if (v > ONE_Q30)
                return 32'sd1073741824;
            else if (v < -ONE_Q30)
                return -32'sd1073741824;
            else
                return v[31:0];
        end
    endfunction

    // q2.30 product rounded half up
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b) + 64'sd536870912;
            return 32'(p >>> 30);
        end
    endfunction

endpackage

// ===== rtl/pixel_pair_covariance.sv =====
// pixel pair covariance element: deep pipeline with cordic sine and cosine
//
// channel   handshake             payload
// in        in_valid/in_ready     row/column index, ra/dec of a and b, overdensities
// out       out_valid/out_ready   cosine_separation, noise_element, data_element
// cfg       cfg_write             cfg_index, cfg_data
//
// one pair per cycle while the output is not stalled
// the pipeline holds the 30 unrolled cordic stages plus reduction and multiplier stages
// reset clears valid bits and loads register defaults; no clearing pass
// a stall at the output freezes every stage at once, nothing is dropped
module pixel_pair_covariance
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         row_index,
    input  logic [15:0]         column_index,
    input  logic [24:0]         ra_a,
    input  logic signed [23:0]  dec_a,
    input  logic [24:0]         ra_b,
    input  logic signed [23:0]  dec_b,
    input  logic signed [31:0]  overdensity_a,
    input  logic signed [31:0]  overdensity_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  cosine_separation,
    output logic [31:0]         noise_element,
    output logic signed [47:0]  data_element,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ppcov_pkg::*;

    localparam int LAST = CORDIC_STEPS + 6;

    logic                en;
    logic [LAST:0]       vld_reg;
    logic [31:0]         diag_reg;
    logic [31:0]         floor_reg;
    logic [31:0]         scale_reg;
    logic                cross_reg;

    // stage 0 capture
    logic signed [25:0]  ang0_reg [3];
    logic signed [31:0]  oda_reg;
    logic signed [31:0]  odb_reg;
    logic [LAST:0]       eq_reg;

    // angle path
    angle_t              red_next [3];
    angle_t              red_reg [3];
    logic [LAST-4:1]     sneg_reg [3];
    logic [LAST-4:1]     cneg_reg [3];
    logic signed [33:0]  cx_reg [3][CORDIC_STEPS+1];
    logic signed [33:0]  cy_reg [3][CORDIC_STEPS+1];
    logic signed [34:0]  cz_reg [3][CORDIC_STEPS+1];
    logic signed [31:0]  sn_reg [3];
    logic signed [31:0]  cs_reg [3];
    logic signed [31:0]  p1_reg;
    logic signed [31:0]  p2_reg;
    logic signed [31:0]  cd_reg;
    logic signed [31:0]  p1d_reg;
    logic signed [31:0]  p3_reg;
    logic signed [31:0]  cos_reg;
    logic signed [32:0]  cos_sum;

    // data path
    logic [31:0]         absa_reg;
    logic [31:0]         absb_reg;
    logic [4:1]          neg_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         hi_reg;
    logic [63:0]         lo_reg;
    logic [52:0]         mag_reg;
    logic [64:0]         mid;
    logic signed [47:0]  data_reg [5:LAST];

    assign en        = !vld_reg[LAST] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];

    assign cosine_separation = cos_reg;
    assign data_element      = data_reg[LAST];
    assign noise_element     = cross_reg ? 32'd0 : (eq_reg[LAST] ? diag_reg : floor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg  <= 32'd65536;
            floor_reg <= 32'd0;
            scale_reg <= 32'd268435456;
            cross_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NOISE_DIAGONAL:   diag_reg  <= cfg_data;
                CFG_NOISE_FLOOR:      floor_reg <= cfg_data;
                CFG_COVARIANCE_SCALE: scale_reg <= cfg_data;
                CFG_CROSS_MODE:       cross_reg <= cfg_data[0];
                default:              cross_reg <= cross_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            red_next[a] = reduce_angle(ang0_reg[a]);
        mid     = 65'(hi_reg) + 65'(lo_reg[63:32]);
        cos_sum = 33'(p1d_reg) + 33'(p3_reg);
    end

    // front stages, sign pipes, cosine products and data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang0_reg[0] <= 26'(dec_a);
            ang0_reg[1] <= 26'(dec_b);
            ang0_reg[2] <= $signed({1'b0, ra_a}) - $signed({1'b0, ra_b});
            oda_reg     <= overdensity_a;
            odb_reg     <= overdensity_b;
            eq_reg      <= {eq_reg[LAST-1:0], row_index == column_index};

            for (int a = 0; a < 3; a++)
            begin
                red_reg[a]  <= red_next[a];
                sneg_reg[a] <= {sneg_reg[a][LAST-5:1], red_next[a].sneg};
                cneg_reg[a] <= {cneg_reg[a][LAST-5:1], red_next[a].cneg};
                cs_reg[a] <= cneg_reg[a][LAST-4] ? -clamp_unit(cx_reg[a][CORDIC_STEPS])
                                                 :  clamp_unit(cx_reg[a][CORDIC_STEPS]);
                sn_reg[a] <= sneg_reg[a][LAST-4] ? -clamp_unit(cy_reg[a][CORDIC_STEPS])
                                                 :  clamp_unit(cy_reg[a][CORDIC_STEPS]);
            end

            p1_reg  <= mul_q30(sn_reg[0], sn_reg[1]);
            p2_reg  <= mul_q30(cs_reg[0], cs_reg[1]);
            cd_reg  <= cs_reg[2];
            p3_reg  <= mul_q30(p2_reg, cd_reg);
            p1d_reg <= p1_reg;
            cos_reg <= clamp_unit(34'(cos_sum));

            absa_reg <= oda_reg[31] ? 32'(-oda_reg) : 32'(oda_reg);
            absb_reg <= odb_reg[31] ? 32'(-odb_reg) : 32'(odb_reg);
            neg_reg  <= {neg_reg[3:1], oda_reg[31] ^ odb_reg[31]};
            prod_reg <= 64'(absa_reg) * 64'(absb_reg);
            hi_reg   <= 64'(prod_reg[63:32]) * 64'(scale_reg);
            lo_reg   <= 64'(prod_reg[31:0]) * 64'(scale_reg);
            mag_reg  <= 53'((mid + 65'd2048) >> 12);
            // saturate the magnitude per sign, then apply the sign
            if (neg_reg[4])
                data_reg[5] <= (mag_reg > DATA_NEG_MAX) ? 48'sh800000000000
                                                        : 48'(-mag_reg);
            else
                data_reg[5] <= (mag_reg > DATA_POS_MAX) ? 48'sh7FFFFFFFFFFF
                                                        : 48'(mag_reg);
            for (int k = 6; k <= LAST; k++)
                data_reg[k] <= data_reg[k-1];
        end
    end

    // one cordic rotation per stage
    for (genvar a = 0; a < 3; a++)
    begin : g_angle
        // degrees to radians q.32, rounded half up
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[a][0] <= INV_GAIN;
                cy_reg[a][0] <= '0;
                cz_reg[a][0] <= 35'(((50'(red_reg[a].mag) * 50'(RAD_SCALE))
                                     + 50'd32768) >> 16);
            end
        end

        for (genvar k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            localparam logic signed [34:0] ATAN_K = atan_step(k);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cz_reg[a][k][34])
                    begin
                        cx_reg[a][k+1] <= cx_reg[a][k] - (cy_reg[a][k] >>> k);
                        cy_reg[a][k+1] <= cy_reg[a][k] + (cx_reg[a][k] >>> k);
                        cz_reg[a][k+1] <= cz_reg[a][k] - ATAN_K;
                    end
                    else
                    begin
                        cx_reg[a][k+1] <= cx_reg[a][k] + (cy_reg[a][k] >>> k);
                        cy_reg[a][k+1] <= cy_reg[a][k] - (cx_reg[a][k] >>> k);
                        cz_reg[a][k+1] <= cz_reg[a][k] + ATAN_K;
                    end
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cross_reg |-> noise_element == 32'd0)
        else $error("noise element not zero in cross mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cosine_separation <= 32'sd1073741824) &&
                      (cosine_separation >= -32'sd1073741824))
        else $error("cosine out of unit range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== verif/testbench.sv =====
// testbench for the pixel pair covariance block: directed and random pairs against a predictor
`timescale 1ns / 1ps

module testbench;
    import ppcov_pkg::*;

    localparam int LATENCY = 37;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] cosine;
        logic [31:0]        noise;
        logic signed [47:0] data;
    } covar_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [15:0] row_index;
    logic [15:0] column_index;
    logic [24:0] ra_a;
    logic signed [23:0] dec_a;
    logic [24:0] ra_b;
    logic signed [23:0] dec_b;
    logic signed [31:0] overdensity_a;
    logic signed [31:0] overdensity_b;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] cosine_separation;
    logic [31:0] noise_element;
    logic signed [47:0] data_element;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    pixel_pair_covariance dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .row_index(row_index),
        .column_index(column_index),
        .ra_a(ra_a),
        .dec_a(dec_a),
        .ra_b(ra_b),
        .dec_b(dec_b),
        .overdensity_a(overdensity_a),
        .overdensity_b(overdensity_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cosine_separation(cosine_separation),
        .noise_element(noise_element),
        .data_element(data_element),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    logic [31:0] diag_reg;
    logic [31:0] floor_reg;
    logic [31:0] scale_reg;
    logic        cross_reg;

    covar_result_t expected_q[$];
    int  error_count;
    int  pairs_sent;
    int  results_seen;
    int  idle_cycles;
    bit  hold_output;
    int  hold_cycles;
    bit  out_stall_on;
    bit  in_gap_on;

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic longint floor_div_pow2(input longint v, input int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint limit_unit(input longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint arctan_q32(input int i);
        longint r;
        case (i)
            0: return 64'sd3373259426;
            1: return 64'sd1991351318;
            2: return 64'sd1052175346;
            3: return 64'sd534100635;
            4: return 64'sd268086748;
            default:
            begin
                r = 64'sd1 <<< (32 - i);
                if (3 * i <= 32)
                    r = r - ((64'sd1 <<< (32 - 3 * i)) / 3);
                if (5 * i <= 32)
                    r = r + ((64'sd1 <<< (32 - 5 * i)) / 5);
                return r;
            end
        endcase
    endfunction

    task automatic angle_sin_cos(input longint deg, output longint s, output longint c);
        bit     sneg;
        bit     cneg;
        longint m;
        longint x;
        longint y;
        longint z;
        longint nx;
        sneg = deg < 0;
        cneg = 1'b0;
        m = sneg ? -deg : deg;
        m = m % 23592960;
        if (m > 11796480)
        begin
            m = 23592960 - m;
            sneg = ~sneg;
        end
        if (m > 5898240)
        begin
            m = 11796480 - m;
            cneg = 1'b1;
        end
        z = (m * 74961321 + 32768) >>> 16;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_div_pow2(y, i);
                y = y + floor_div_pow2(x, i);
                z = z - arctan_q32(i);
            end
            else
            begin
                nx = x + floor_div_pow2(y, i);
                y = y - floor_div_pow2(x, i);
                z = z + arctan_q32(i);
            end
            x = nx;
        end
        x = limit_unit(x);
        y = limit_unit(y);
        c = cneg ? -x : x;
        s = sneg ? -y : y;
    endtask

    function automatic longint q30_product(input longint a, input longint b);
        return floor_div_pow2(a * b + (64'sd1 <<< 29), 30);
    endfunction

    task automatic predict_pair(input logic [15:0] row, input logic [15:0] col,
                                input logic [24:0] ra_1, input logic signed [23:0] dec_1,
                                input logic [24:0] ra_2, input logic signed [23:0] dec_2,
                                input logic signed [31:0] od_1,
                                input logic signed [31:0] od_2);
        longint sa, ca, sb, cb, sd, cd, cosv;
        logic [63:0] prod, hi, lo, mid, mag;
        logic [63:0] abs1, abs2;
        bit neg;
        covar_result_t r;
        angle_sin_cos(longint'(dec_1), sa, ca);
        angle_sin_cos(longint'(dec_2), sb, cb);
        angle_sin_cos(longint'(ra_1) - longint'(ra_2), sd, cd);
        cosv = limit_unit(q30_product(sa, sb) + q30_product(q30_product(ca, cb), cd));
        r.cosine = cosv[31:0];
        if (cross_reg)
            r.noise = '0;
        else
            r.noise = (row == col) ? diag_reg : floor_reg;
        neg = (od_1 < 0) != (od_2 < 0);
        abs1 = od_1 < 0 ? -longint'(od_1) : longint'(od_1);
        abs2 = od_2 < 0 ? -longint'(od_2) : longint'(od_2);
        prod = abs1 * abs2;
        hi = (prod >> 32) * {32'd0, scale_reg};
        lo = (prod & 64'hFFFF_FFFF) * {32'd0, scale_reg};
        mid = hi + (lo >> 32);
        mag = (mid + 64'd2048) >> 12;
        if (neg)
        begin
            if (mag > 64'd140737488355328)
                mag = 64'd140737488355328;
            mag = -mag;
        end
        else if (mag > 64'd140737488355327)
            mag = 64'd140737488355327;
        r.data = mag[47:0];
        expected_q.push_back(r);
    endtask

    // write enable drops for one cycle between writes
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_NOISE_DIAGONAL:   diag_reg = value;
            CFG_NOISE_FLOOR:      floor_reg = value;
            CFG_COVARIANCE_SCALE: scale_reg = value;
            CFG_CROSS_MODE:       cross_reg = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // valid stays up across back-to-back beats; only lowered during a gap
    task automatic send_pair(input logic [15:0] row, input logic [15:0] col,
                             input logic [24:0] ra_1, input logic signed [23:0] dec_1,
                             input logic [24:0] ra_2, input logic signed [23:0] dec_2,
                             input logic signed [31:0] od_1,
                             input logic signed [31:0] od_2);
        int gap;
        gap = in_gap_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        row_index     <= row;
        column_index  <= col;
        ra_a          <= ra_1;
        dec_a         <= dec_1;
        ra_b          <= ra_2;
        dec_b         <= dec_2;
        overdensity_a <= od_1;
        overdensity_b <= od_2;
        predict_pair(row, col, ra_1, dec_1, ra_2, dec_2, od_1, od_2);
        do
            @(posedge clk);
        while (!in_ready);
        pairs_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_dec(input bit any_pattern);
        if (any_pattern)
            return 24'($urandom);
        return 24'($signed($urandom_range(0, 11796480)) - 5898240);
    endfunction

    task automatic send_random_pair(input bit wild, input bit diag);
        logic [15:0] r;
        logic [15:0] c;
        logic [24:0] ra1, ra2;
        logic signed [31:0] o1, o2;
        r = 16'($urandom);
        c = diag ? r : 16'($urandom);
        ra1 = wild ? 25'($urandom) : 25'($urandom_range(0, 23592960));
        ra2 = wild ? 25'($urandom) : 25'($urandom_range(0, 23592960));
        case ($urandom_range(0, 3))
            0: o1 = $urandom;
            1: o1 = $signed($urandom_range(0, 33554432)) - 16777216;
            2: o1 = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: o1 = $signed($urandom_range(0, 8388608)) - 4194304;
        endcase
        o2 = $urandom_range(0, 1) ? 32'($urandom) : 32'($signed($urandom_range(0, 67108864)) - 33554432);
        send_pair(r, c, ra1, random_dec(wild), ra2, random_dec(wild), o1, o2);
    endtask

    task automatic test_directed_extremes;
        send_pair(16'd0, 16'd0, 25'd0, 24'sd0, 25'd0, 24'sd0, 32'sd16777216, 32'sd16777216);
        send_pair(16'hFFFF, 16'hFFFF, 25'd23592960, 24'sd5898240, 25'd0, -24'sd5898240,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_pair(16'd0, 16'hFFFF, 25'd11796480, 24'sd5898240, 25'd0, 24'sd5898240,
                  32'sh8000_0000, 32'sh8000_0000);
        send_pair(16'h1234, 16'h1235, 25'd5898240, 24'sd0, 25'd0, 24'sd0,
                  32'sh8000_0000, 32'sh7FFF_FFFF);
        send_pair(16'hAAAA, 16'h5555, 25'h1FF_FFFF, 24'sh7F_FFFF, 25'd0, 24'sh80_0000,
                  32'sd0, -32'sd1);
        send_pair(16'h5555, 16'h5555, 25'd17694720, -24'sd2949120, 25'd1, 24'sd1,
                  -32'sd16777216, 32'sd33554432);
        send_pair(16'd7, 16'd9, 25'd23592959, 24'sh55_5555, 25'h0AA_AAAA, 24'shAA_AAAA,
                  32'sh5555_5555, 32'shAAAA_AAAA);
        send_pair(16'd100, 16'd100, 25'd11796480, -24'sd5898240, 25'd11796480, 24'sd5898240,
                  32'sd1, 32'sd1);
        drain();
    endtask

    task automatic test_register_extremes;
        write_register(CFG_NOISE_DIAGONAL, 32'hFFFF_FFFF);
        write_register(CFG_NOISE_FLOOR, 32'hFFFF_FFFF);
        write_register(CFG_COVARIANCE_SCALE, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            send_random_pair(i[0], i[1]);
        drain();
        write_register(CFG_NOISE_DIAGONAL, 32'd0);
        write_register(CFG_NOISE_FLOOR, 32'h1234_5678);
        write_register(CFG_COVARIANCE_SCALE, 32'd0);
        write_register(CFG_CROSS_MODE, 32'd1);
        for (int i = 0; i < 12; i++)
            send_random_pair(i[0], i[1]);
        drain();
        write_register(CFG_CROSS_MODE, 32'd0);
    endtask

    task automatic test_random_pairs(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 50)
            begin
                drain();
                write_register(CFG_NOISE_DIAGONAL, $urandom);
                write_register(CFG_NOISE_FLOOR, $urandom);
                write_register(CFG_COVARIANCE_SCALE, $urandom);
                write_register(CFG_CROSS_MODE, $urandom_range(0, 1));
            end
            in_gap_on = (i / 40) % 3 != 2;
            out_stall_on = (i / 60) % 3 != 1;
            send_random_pair($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
        end
        drain();
    endtask

    task automatic test_backpressure;
        in_gap_on = 1'b0;
        hold_cycles = 120;
        hold_output = 1'b1;
        for (int i = 0; i < 80; i++)
            send_random_pair(1'b0, i[2]);
        drain();
        in_gap_on = 1'b1;
    endtask

    // receiver: random stalls plus an optional long hold counted here
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (out_stall_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        covar_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat cos=%0d noise=%0d data=%0d", $time,
                         cosine_separation, noise_element, data_element);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (cosine_separation !== want.cosine)
                begin
                    $display("%0t: cosine_separation expected %0d actual %0d", $time,
                             want.cosine, cosine_separation);
                    error_count++;
                end
                if (noise_element !== want.noise)
                begin
                    $display("%0t: noise_element expected %0d actual %0d", $time,
                             want.noise, noise_element);
                    error_count++;
                end
                if (data_element !== want.data)
                begin
                    $display("%0t: data_element expected %0d actual %0d", $time,
                             want.data, data_element);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        row_index <= '0;
        column_index <= '0;
        ra_a <= '0;
        dec_a <= '0;
        ra_b <= '0;
        dec_b <= '0;
        overdensity_a <= '0;
        overdensity_b <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_NOISE_DIAGONAL;
        cfg_data <= '0;
        error_count = 0;
        pairs_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_output = 1'b0;
        hold_cycles = 0;
        out_stall_on = 1'b1;
        in_gap_on = 1'b1;
        diag_reg = 32'd65536;
        floor_reg = 32'd0;
        scale_reg = 32'd268435456;
        cross_reg = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_extremes();
        test_backpressure();
        test_random_pairs(400);

        $display("covered %0d pairs and %0d result beats: angle extremes, index match,",
                 pairs_sent, results_seen);
        $display("saturation, cross mode, register extremes and a long output stall");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ppcov_pkg.sv
rtl/pixel_pair_covariance.sv
verif/testbench.sv
